>>> rtl/jdfh_pkg.sv
// Package: shared types, codes and constants of the job dispatch block.
`timescale 1ns / 1ps
`default_nettype none
package jdfh_pkg;

  localparam int MaxJobsDef = 16;

  localparam logic FUNC_ADD      = 1'b0;
  localparam logic FUNC_DISPATCH = 1'b1;

  localparam logic [1:0] ST_ADDED      = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_DISPATCHED = 2'd2;
  localparam logic [1:0] ST_EMPTY      = 2'd3;

  localparam logic MODE_FCFS = 1'b0;
  localparam logic MODE_HRRN = 1'b1;

  // Fields of one job as stored in the table memory.
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] run;
    logic [31:0] order;
  } slot_t;

  localparam int SlotW = $bits(slot_t);

  typedef struct packed {
    logic        func;
    logic [7:0]  job_id;
    logic [15:0] arrive_time;
    logic [15:0] run_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  chosen_id;
    logic [31:0] finish_time;
    logic [31:0] turnaround;
    logic [31:0] weighted_turnaround;
  } out_word_t;

  // Divider handshake between the controller and the divide unit.
  typedef struct packed {
    logic        start;
    logic [39:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_HRRN_MUL,
    S_HRRN_CMP,
    S_RUN,
    S_DIV,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> rtl/jdfh_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module jdfh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> rtl/jdfh_div.sv
// Restoring divider: 40-bit dividend by 16-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module jdfh_div
  import jdfh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output logic          done,
  output logic [39:0]   quot
);
  logic [39:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] d_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [16:0] trial;

  // shift in one dividend bit, subtract if it fits
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[15:0], q_r[39]};
    if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[38:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[38:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd40;
      q_r    <= req.dividend;
      rem_r  <= '0;
      d_r    <= req.divisor;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      q_r    <= q_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign done = busy_r && (cnt_r == 6'd1);
  assign quot = q_nxt;
endmodule
`default_nettype wire

>>> rtl/job_dispatch_fcfs_hrrn.sv
// Top level: job table scheduler with FCFS and HRRN dispatch.
// Add and empty dispatch: busy only in the done state; the result word is strobed after it.
// Dispatch: two scan passes over every slot (read, capture, ratio multiply, compare),
//   then a run state that launches the divider, the divide and a done state.
// One item at a time; receiver cannot stall; busy drops in the cycle out_valid pulses.
// Synchronous active-low reset clears valid flags, time, counter and policy.
`timescale 1ns / 1ps
`default_nettype none
module job_dispatch_fcfs_hrrn
  import jdfh_pkg::*;
#(
  parameter int MAX_JOBS = MaxJobsDef
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  output out_word_t      out_word,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);
  localparam int IdxW = $clog2(MAX_JOBS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_JOBS - 1);

  state_t state_r, state_nxt;
  logic [MAX_JOBS-1:0] valid_r;
  logic [31:0] now_r, cnt_ins_r;
  logic        mode_r;
  logic [IdxW-1:0] scan_r;
  logic        pass_r;
  logic [IdxW-1:0] pick_r;
  logic        have_r, pick_arr_r, any_arr_r;
  slot_t       best_r, cand_r;
  logic [47:0] lhs_r, rhs_r;
  logic [31:0] fin_r, turn_r;
  out_word_t   res_r;
  logic        res_v_r;

  logic        ram_we;
  logic [IdxW-1:0] ram_addr;
  slot_t       ram_wdata, ram_rdata;

  div_req_t    dreq;
  logic        ddone;
  logic [39:0] dquot;

  // lowest free slot
  logic [IdxW-1:0] free_idx;
  logic            free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = MAX_JOBS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = i[IdxW-1:0];
        free_any = 1'b1;
      end
    end
  end

  // status of a word finished in the idle state
  logic [1:0] idle_status;
  always_comb begin
    if (in_word.func == FUNC_ADD) idle_status = free_any ? ST_ADDED : ST_FULL;
    else                          idle_status = ST_EMPTY;
  end

  jdfh_ram #(.Width(SlotW), .Depth(MAX_JOBS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  jdfh_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dquot));

  // comparisons of the candidate against the current best
  logic cand_arr, fcfs_lt;
  assign cand_arr = {16'd0, cand_r.arrival} <= now_r;
  always_comb begin
    if (cand_r.arrival != best_r.arrival)  fcfs_lt = cand_r.arrival < best_r.arrival;
    else if (cand_r.run != best_r.run)     fcfs_lt = cand_r.run < best_r.run;
    else                                   fcfs_lt = cand_r.order < best_r.order;
  end

  logic        use_hrrn;
  assign use_hrrn = (mode_r == MODE_HRRN) && any_arr_r;

  // finish time, saturated, and turnaround of the picked job
  logic [31:0] start_t;
  logic [32:0] fin_full;
  logic [31:0] fin_sat, turn_c;
  assign start_t  = (now_r > {16'd0, best_r.arrival}) ? now_r : {16'd0, best_r.arrival};
  assign fin_full = {1'b0, start_t} + {17'd0, best_r.run};
  assign fin_sat  = fin_full[32] ? 32'hFFFF_FFFF : fin_full[31:0];
  assign turn_c   = fin_sat - {16'd0, best_r.arrival};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_word.func == FUNC_ADD) state_nxt = S_DONE;
          else if (valid_r == '0)       state_nxt = S_DONE;
          else                          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: state_nxt = S_HRRN_MUL;
      S_HRRN_MUL: state_nxt = S_HRRN_CMP;
      S_HRRN_CMP: begin
        if (pass_r && scan_r == LastIdx) state_nxt = S_RUN;
        else                             state_nxt = S_SCAN_RD;
      end
      S_RUN: state_nxt = S_DIV;
      S_DIV: if (ddone) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory access and divider launch
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = scan_r;
    ram_wdata = '0;
    dreq      = '0;
    if (state_r == S_IDLE && start && in_word.func == FUNC_ADD) begin
      ram_we          = free_any;
      ram_addr        = free_idx;
      ram_wdata.id    = in_word.job_id;
      ram_wdata.arrival = in_word.arrive_time;
      ram_wdata.run   = (in_word.run_time == 16'd0) ? 16'd1 : in_word.run_time;
      ram_wdata.order = cnt_ins_r;
    end
    if (state_r == S_RUN) begin
      dreq.start    = 1'b1;
      dreq.dividend = {turn_c, 8'd0};
      dreq.divisor  = best_r.run;
    end
  end

  // Scan runs two passes: first finds whether any valid slot arrived,
  // second picks. pass_r selects the pass.
  logic cur_valid, better;
  assign cur_valid = valid_r[scan_r];
  always_comb begin
    better = 1'b0;
    if (use_hrrn) begin
      if (cand_arr) begin
        if (!have_r || !pick_arr_r) better = 1'b1;
        else if (lhs_r != rhs_r)    better = lhs_r > rhs_r;
        else                        better = fcfs_lt;
      end
    end else begin
      better = !have_r || fcfs_lt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      now_r     <= '0;
      cnt_ins_r <= '0;
      mode_r    <= MODE_FCFS;
      res_v_r   <= 1'b0;
      scan_r    <= '0;
      pass_r    <= 1'b0;
      have_r    <= 1'b0;
      any_arr_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_v_r <= 1'b0;
      if (cfg_we) mode_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            scan_r    <= '0;
            pass_r    <= 1'b0;
            have_r    <= 1'b0;
            any_arr_r <= 1'b0;
            res_r.status              <= idle_status;
            res_r.chosen_id           <= '0;
            res_r.finish_time         <= '0;
            res_r.turnaround          <= '0;
            res_r.weighted_turnaround <= '0;
            if (in_word.func == FUNC_ADD && free_any) begin
              valid_r[free_idx] <= 1'b1;
              cnt_ins_r <= cnt_ins_r + 32'd1;
            end
          end
        end
        S_SCAN_RD: ;
        S_SCAN_CMP: cand_r <= ram_rdata;
        S_HRRN_MUL: begin
          lhs_r <= (now_r - {16'd0, cand_r.arrival}) * best_r.run;
          rhs_r <= (now_r - {16'd0, best_r.arrival}) * cand_r.run;
        end
        S_HRRN_CMP: begin
          if (cur_valid) begin
            if (!pass_r) begin
              if (cand_arr) any_arr_r <= 1'b1;
            end else if (better) begin
              best_r     <= cand_r;
              pick_r     <= scan_r;
              have_r     <= 1'b1;
              pick_arr_r <= cand_arr;
            end
          end
          if (scan_r == LastIdx) begin
            scan_r <= '0;
            pass_r <= 1'b1;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        S_RUN: begin
          fin_r <= fin_sat;
        end
        S_DIV: begin
          if (ddone) begin
            now_r           <= fin_r;
            valid_r[pick_r] <= 1'b0;
            res_r.status    <= ST_DISPATCHED;
            res_r.chosen_id <= best_r.id;
            res_r.finish_time <= fin_r;
            res_r.turnaround  <= turn_r;
            res_r.weighted_turnaround <= (dquot[39:32] != 8'd0) ? 32'hFFFF_FFFF
                                                                : dquot[31:0];
          end
        end
        S_DONE: res_v_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // turnaround from saturated finish, held through the divide
  always_ff @(posedge clk) begin
    if (state_r == S_RUN) begin
      turn_r <= turn_c;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = res_v_r;
  assign out_word  = res_r;

  // pass-one scan never changes the pick
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HRRN_CMP && !pass_r) |=> $stable(have_r))
    else $error("pick changed in first scan pass");
  // a dispatch removes exactly one job
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && ddone) |=> ($countones(valid_r) == $countones($past(valid_r)) - 1))
    else $error("dispatch did not clear one slot");
  // result strobe only after the done state
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DONE))
    else $error("stray result strobe");
endmodule
`default_nettype wire

>>> dv/testbench.sv
// Testbench for the job dispatch table scheduler in FCFS and HRRN modes.
`timescale 1ns / 1ps
module testbench;
  import jdfh_pkg::*;

  localparam int NumSlots = MaxJobsDef;

  // Shadow copy of the job table; predicts each result word and keeps the queue.
  class dispatch_scoreboard;
    bit          valid_q[NumSlots];
    logic [7:0]  id_q[NumSlots];
    logic [15:0] arr_q[NumSlots];
    logic [15:0] run_q[NumSlots];
    logic [31:0] ord_q[NumSlots];
    logic [31:0] now;
    logic [31:0] next_order;
    logic        mode;
    out_word_t   pending[$];
    int          errors;

    function new();
      for (int i = 0; i < NumSlots; i++) valid_q[i] = 0;
      now = 0;
      next_order = 0;
      mode = MODE_FCFS;
      errors = 0;
    endfunction

    function bit fcfs_ahead(int a, int b);
      if (arr_q[a] != arr_q[b]) return arr_q[a] < arr_q[b];
      if (run_q[a] != run_q[b]) return run_q[a] < run_q[b];
      return ord_q[a] < ord_q[b];
    endfunction

    // Compare response ratios exactly by cross-multiplying waits and runs.
    function bit ratio_ahead(int a, int b);
      logic [63:0] lhs;
      logic [63:0] rhs;
      lhs = 64'(now - 32'(arr_q[a])) * 64'(run_q[b]);
      rhs = 64'(now - 32'(arr_q[b])) * 64'(run_q[a]);
      if (lhs != rhs) return lhs > rhs;
      return fcfs_ahead(a, b);
    endfunction

    function void note_word(in_word_t w);
      out_word_t   r;
      int          pick;
      bit          arrived;
      logic [31:0] start_t;
      logic [32:0] fin;
      logic [31:0] turn;
      logic [63:0] wt;
      r = '0;
      pick = -1;
      arrived = 0;
      if (w.func == FUNC_ADD) begin
        for (int i = 0; i < NumSlots; i++)
          if (!valid_q[i] && pick < 0) pick = i;
        if (pick < 0) begin
          r.status = ST_FULL;
        end else begin
          valid_q[pick] = 1;
          id_q[pick] = w.job_id;
          arr_q[pick] = w.arrive_time;
          run_q[pick] = (w.run_time == 0) ? 16'd1 : w.run_time;
          ord_q[pick] = next_order;
          next_order++;
          r.status = ST_ADDED;
        end
      end else begin
        if (mode == MODE_HRRN)
          for (int i = 0; i < NumSlots; i++)
            if (valid_q[i] && 32'(arr_q[i]) <= now) begin
              arrived = 1;
              if (pick < 0 || ratio_ahead(i, pick)) pick = i;
            end
        if (!arrived) begin
          pick = -1;
          for (int i = 0; i < NumSlots; i++)
            if (valid_q[i] && (pick < 0 || fcfs_ahead(i, pick))) pick = i;
        end
        if (pick < 0) begin
          r.status = ST_EMPTY;
        end else begin
          start_t = (now > 32'(arr_q[pick])) ? now : 32'(arr_q[pick]);
          fin = 33'(start_t) + 33'(run_q[pick]);
          r.finish_time = fin[32] ? 32'hFFFF_FFFF : fin[31:0];
          turn = r.finish_time - 32'(arr_q[pick]);
          wt = {24'd0, turn, 8'd0} / 64'(run_q[pick]);
          r.weighted_turnaround = (wt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wt[31:0];
          r.turnaround = turn;
          r.chosen_id = id_q[pick];
          r.status = ST_DISPATCHED;
          now = r.finish_time;
          valid_q[pick] = 0;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status) begin
        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.chosen_id != want.chosen_id) begin
        $display("%0t: chosen_id exp %0d got %0d", $time, want.chosen_id, got.chosen_id);
        errors++;
      end
      if (got.finish_time != want.finish_time) begin
        $display("%0t: finish_time exp %0d got %0d", $time, want.finish_time,
                 got.finish_time);
        errors++;
      end
      if (got.turnaround != want.turnaround) begin
        $display("%0t: turnaround exp %0d got %0d", $time, want.turnaround, got.turnaround);
        errors++;
      end
      if (got.weighted_turnaround != want.weighted_turnaround) begin
        $display("%0t: weighted_turnaround exp %0d got %0d", $time,
                 want.weighted_turnaround, got.weighted_turnaround);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;
  logic      cfg_we = 0;
  logic      cfg_wdata = 0;

  dispatch_scoreboard sb = new();

  job_dispatch_fcfs_hrrn dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Check every strobed result word.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_word(out_word);
  end

  // Present one word, wait while the block is busy, note it and drop start.
  task automatic send_word(in_word_t w);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(w);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_job(logic [7:0] id, logic [15:0] arr, logic [15:0] run);
    in_word_t w;
    w.func = FUNC_ADD;
    w.job_id = id;
    w.arrive_time = arr;
    w.run_time = run;
    send_word(w);
  endtask

  task automatic dispatch_job();
    in_word_t w;
    w = in_word_t'($bits(in_word_t)'({$urandom, $urandom}));
    w.func = FUNC_DISPATCH;
    send_word(w);
  endtask

  // Drain expected words, let the block settle, then write the policy.
  task automatic set_mode(logic m);
    int guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (150) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.mode = m;
  endtask

  // Random phase: mostly short arrival spreads, sometimes full-range fields.
  task automatic random_phase(int count);
    int depth;
    depth = 0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < ((depth > 12) ? 35 : 55)) begin
        if ($urandom_range(0, 9) == 0)
          add_job(8'($urandom), 16'($urandom), 16'($urandom));
        else
          add_job(8'($urandom), 16'(sb.now[15:0] + $urandom_range(0, 300)),
                  16'($urandom_range(0, 200)));
        if (depth < NumSlots) depth++;
      end else begin
        dispatch_job();
        if (depth > 0) depth--;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extremes, ties, zero run, full table.
    dispatch_job();
    add_job(8'hFF, 16'hFFFF, 16'hFFFF);
    add_job(8'h00, 16'd0, 16'd0);
    add_job(8'h11, 16'd5, 16'd3);
    add_job(8'h12, 16'd5, 16'd3);
    add_job(8'h13, 16'd5, 16'd2);
    repeat (5) dispatch_job();
    dispatch_job();
    for (int i = 0; i < NumSlots + 2; i++) add_job(8'(i), 16'(i * 7), 16'(i + 1));
    set_mode(MODE_HRRN);
    repeat (NumSlots) dispatch_job();
    add_job(8'hA0, 16'hFFFF, 16'd10);
    add_job(8'hA1, 16'hFFF0, 16'd1);
    dispatch_job();
    dispatch_job();
    dispatch_job();

    for (int p = 0; p < 6; p++) begin
      set_mode(p[0] ? MODE_HRRN : MODE_FCFS);
      random_phase(300);
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end
endmodule
